// ----- hdl/ovla_pkg.sv -----
`default_nettype none

package ovla_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int ACC_W       = 24;
    localparam int SAMPLE_W    = 16;
    localparam int HOP_W       = 7;

    localparam logic [HOP_W-1:0] HOP_RESET = 7'd32;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 24'sh800000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_EMIT_RD,
        ST_EMIT_LD
    } ovla_state_t;

    // One cycle's worth of store commands from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ACC_W-1:0]  wr_data;
        logic              clr_en;
        logic [ADDR_W-1:0] clr_addr;
    } store_req_t;

    // Add a Q1.15 sample into a Q9.15 accumulator and clamp to 24 bits
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [SAMPLE_W-1:0] smp);
        logic [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat_add = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_add = sum[ACC_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ovla_store.sv -----
`default_nettype none

module ovla_store (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire ovla_pkg::store_req_t       req,
    output logic [ovla_pkg::ACC_W-1:0]      rd_data
);
    import ovla_pkg::*;

    logic [ACC_W-1:0]       mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [ACC_W-1:0]       rd_data_reg;
    logic                   rd_vld_reg;

    // Write the accumulated word
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read; hold the last word when no read is issued
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Track written entries; an entry without its bit reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.clr_en) begin
                valid_reg[req.clr_addr] <= 1'b0;
            end
            if (req.rd_en) begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ----- hdl/overlap_add_accumulator_top.sv -----
`default_nettype none

// Overlap-add output accumulator. Frame samples (signed Q1.15) enter on the
// s_ stream, FRAME_SIZE per frame in position order; each is added with
// 24-bit saturation into a 64-word circular store at base plus position.
// After the last sample of a frame the oldest min(hop_size, FRAME_SIZE)
// words come out on the m_ stream in order (Q9.15), m_tlast on the final
// one, and those words are retired and the base advances by the hop. Every
// sample takes a read of the store and then a write of the saturating
// adder result, and no new sample is taken until that write. After the
// last sample of a frame each emitted word takes a read, then a load of
// the output register, which waits while m_tready is low on an offered
// word. The store is cleared at reset through per-word valid flags, so
// no clearing pass is needed and s_tready rises as soon as reset is
// released. hop_size is written on the cfg channel, which is ready
// whenever reset is released, and must only change while the block is
// idle.
module overlap_add_accumulator_top #(
    parameter int FRAME_SIZE = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config: hop_size[6:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    // s_tdata: sample_in[15:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    // m_tdata: sample_out[23:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    // m_tlast: hop_last
    output logic             m_tlast
);
    import ovla_pkg::*;

    localparam int POS_W = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_SIZE - 1);
    localparam logic [HOP_W-1:0] HOP_LIMIT = HOP_W'(FRAME_SIZE);

    ovla_state_t        state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [HOP_W-1:0]   k_reg, k_next;
    logic [HOP_W-1:0]   hop_cur_reg, hop_cur_next;
    logic [HOP_W-1:0]   hop_reg;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic               out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]   out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    store_req_t         req;
    logic [ACC_W-1:0]   rd_data;
    logic [HOP_W-1:0]   hop_eff;
    logic [ADDR_W-1:0]  acc_addr;
    logic [ADDR_W-1:0]  emit_addr;
    logic               out_free;
    logic               emit_last;

    ovla_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rd_data)
    );

    // Hold the hop register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_reg <= HOP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            hop_reg <= cfg_data;
        end
    end

    assign cfg_ready = aresetn;
    assign hop_eff   = (hop_reg > HOP_LIMIT) ? HOP_LIMIT : hop_reg;
    assign acc_addr  = base_reg + ADDR_W'(pos_reg);
    assign emit_addr = base_reg + k_reg[ADDR_W-1:0];
    assign out_free  = !out_valid_reg || m_tready;
    assign emit_last = (k_reg + 1'b1) == hop_cur_reg;

    // Sequence the read-modify-write and the emit sweep
    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        base_next      = base_reg;
        k_next         = k_reg;
        hop_cur_next   = hop_cur_reg;
        smp_next       = smp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        s_tready       = 1'b0;
        req            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    smp_next    = s_tdata;
                    req.rd_en   = 1'b1;
                    req.rd_addr = acc_addr;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC: begin
                req.wr_en   = 1'b1;
                req.wr_addr = acc_addr;
                req.wr_data = sat_add(rd_data, smp_reg);
                if (pos_reg == POS_LAST) begin
                    pos_next     = '0;
                    hop_cur_next = hop_eff;
                    k_next       = '0;
                    state_next   = (hop_eff == '0) ? ST_IDLE : ST_EMIT_RD;
                end else begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = emit_addr;
                state_next  = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data;
                    out_last_next  = emit_last;
                    req.clr_en     = 1'b1;
                    req.clr_addr   = emit_addr;
                    if (emit_last) begin
                        base_next  = base_reg + hop_cur_reg[ADDR_W-1:0];
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            base_reg      <= '0;
            k_reg         <= '0;
            hop_cur_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            base_reg      <= base_next;
            k_reg         <= k_next;
            hop_cur_reg   <= hop_cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the sample and the output word
    always_ff @(posedge aclk) begin
        smp_reg      <= smp_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/ovla_checker.sv -----
`default_nettype none

module ovla_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled output word stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Each accepted sample occupies the adder, so the input is not taken back to back
    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind overlap_add_accumulator_top ovla_checker u_ovla_checker (.*);

`default_nettype wire

// ----- test/overlap_add_accumulator_top_tb.sv -----
`timescale 1ns / 100ps

module overlap_add_accumulator_top_tb;

    import ovla_pkg::*;

    localparam int FRAME      = 64;
    localparam int QUIET      = 16;    // settle time before a hop_size write
    localparam int WATCHDOG   = 4000;

    typedef enum logic [1:0] {
        JOB_SAMPLE,
        JOB_HOP,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t   kind;
        logic [15:0] value;
        logic [1:0]  mode;
    } job_t;

    typedef struct {
        logic [ACC_W-1:0] sample_out;
        logic             hop_last;
    } word_t;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [6:0]       cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [23:0]      m_tdata;
    logic             m_tlast;

    // Pending stimulus and words still owed by the block
    job_t             job_q[$];
    word_t            due_words[$];
    int               queued;
    int               err_count;

    // Shadow of the accumulator state
    logic signed [ACC_W-1:0] acc_store [STORE_DEPTH];
    logic [ADDR_W-1:0]       acc_base;
    int                      acc_pos;
    logic [HOP_W-1:0]        acc_hop;

    logic             drained  = 1'b1;
    int               quiet    = 0;
    logic [1:0]       cur_mode = '0;
    int               stall_run = 0;

    // Idle percentages per mode: sender, then receiver
    int send_gap [3] = '{28, 75, 0};
    int recv_gap [3] = '{75, 28, 0};

    overlap_add_accumulator_top #(
        .FRAME_SIZE (FRAME)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Add one sample at its frame position; at frame end, owe the oldest hop words
    task automatic add_frame_sample(input logic signed [SAMPLE_W-1:0] smp);
        int                sum;
        int                hop;
        logic [ADDR_W-1:0] a;
        word_t             w;
        a = acc_base + ADDR_W'(acc_pos);
        sum = int'(acc_store[a]) + int'(smp);
        if (sum > int'(ACC_MAX)) begin
            sum = int'(ACC_MAX);
        end else if (sum < int'(ACC_MIN)) begin
            sum = int'(ACC_MIN);
        end
        acc_store[a] = ACC_W'(sum);
        if (acc_pos + 1 < FRAME) begin
            acc_pos++;
        end else begin
            acc_pos = 0;
            hop = (acc_hop > FRAME) ? FRAME : int'(acc_hop);
            for (int k = 0; k < hop; k++) begin
                a = acc_base + ADDR_W'(k);
                w.sample_out = acc_store[a];
                w.hop_last   = (k == hop - 1);
                due_words.push_back(w);
                acc_store[a] = '0;
            end
            acc_base = acc_base + ADDR_W'(hop);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // First frame idles the sender lightly, then swap, then run flat out
    task automatic queue_sample(input logic [15:0] v);
        logic [1:0] m;
        m = (queued < FRAME) ? 2'd0 : (queued < FRAME + FRAME / 2) ? 2'd1 : 2'd2;
        job_q.push_back('{JOB_SAMPLE, v, m});
        queued++;
    endtask

    task automatic queue_hop(input logic [HOP_W-1:0] v);
        job_q.push_back('{JOB_HOP, 16'(v), 2'd0});
    endtask

    // Track the block: predict on accepted samples, check accepted words
    always @(posedge aclk) begin
        word_t w;
        if (!aresetn) begin
            foreach (acc_store[i]) acc_store[i] = '0;
            acc_base = '0;
            acc_pos  = 0;
            acc_hop  = HOP_RESET;
            due_words.delete();
            drained <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                acc_hop = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                add_frame_sample(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (due_words.size() == 0) begin
                    $error("unexpected word: sample_out %0d, hop_last %0b",
                           $signed(m_tdata), m_tlast);
                    err_count++;
                end else begin
                    w = due_words.pop_front();
                    check_field("sample_out", int'($signed(w.sample_out)),
                                int'($signed(m_tdata)));
                    check_field("hop_last", int'(w.hop_last), int'(m_tlast));
                end
            end
            drained <= (due_words.size() == 0);
        end
    end

    // Feed queued jobs to the block; hop writes wait for a drained, quiet block
    always @(posedge aclk) begin
        logic give;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            m_tready  <= 1'b0;
            quiet     <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_gap[cur_mode]);
            quiet    <= (drained && !s_tvalid && !cfg_valid) ? quiet + 1 : 0;
            if (cfg_valid) begin
                if (cfg_ready) begin
                    cfg_valid <= 1'b0;
                    void'(job_q.pop_front());
                end
            end else if (!s_tvalid || s_tready) begin
                give = 1'b0;
                if (job_q.size() != 0) begin
                    case (job_q[0].kind)
                        JOB_SAMPLE: begin
                            if ($urandom_range(99) >= send_gap[job_q[0].mode]) begin
                                give     = 1'b1;
                                s_tdata  <= job_q[0].value;
                                cur_mode <= job_q[0].mode;
                                void'(job_q.pop_front());
                            end
                        end
                        JOB_DRAIN: begin
                            if (drained && !s_tvalid) begin
                                void'(job_q.pop_front());
                            end
                        end
                        JOB_HOP: begin
                            if (drained && !s_tvalid && quiet >= QUIET) begin
                                cfg_valid <= 1'b1;
                                cfg_data  <= job_q[0].value[HOP_W-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                s_tvalid <= give;
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_run <= 0;
        end else begin
            stall_run <= stall_run + 1;
        end
        if (stall_run >= WATCHDOG) begin
            $display("overlap_add_accumulator_top: mismatch");
            $finish;
        end
    end

    initial begin
        logic [15:0] v;
        queued    = 0;
        err_count = 0;

        // Reset hop: field extremes and walking ones lead the frame
        for (int p = 0; p < FRAME; p++) begin
            case (p)
                0:       v = 16'h7FFF;
                1:       v = 16'h8000;
                2:       v = 16'h0000;
                3:       v = 16'hFFFF;
                default: v = (p < 20) ? 16'(1 << (p - 4)) : 16'($urandom);
            endcase
            queue_sample(v);
        end

        // Hop beyond the frame clamps to a full frame over the retained half;
        // the write itself waits until every owed word has come
        queue_hop(7'd127);
        for (int p = 0; p < FRAME; p++) queue_sample(16'($urandom));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (job_q.size() != 0 || s_tvalid || cfg_valid || !drained) begin
            @(posedge aclk);
        end
        repeat (QUIET) @(posedge aclk);
        if (due_words.size() != 0) begin
            $error("%0d expected words never arrived", due_words.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("overlap_add_accumulator_top: match");
        end else begin
            $display("overlap_add_accumulator_top: mismatch");
        end
        $finish;
    end

endmodule
